### hw/rtl/fcd_pkg.sv
// Shared constants, types and helpers of the corner detector.
package fcd_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 13;

    localparam logic [CFG_AW-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_RATIO  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ARC    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_PRE    = 3'd4;

    // Centre position and 16 circle pixels handed from front to back.
    typedef struct packed {
        logic [9:0]       x;
        logic [11:0]      y;
        logic [7:0]       ctr;
        logic [15:0][7:0] circ;
    } cand_t;

    typedef struct packed {
        logic [6:0] ratio;
        logic [4:0] arc;
        logic [2:0] pre;
    } thr_cfg_t;

    // Circle offsets, row then column into the 7x7 window, index 3 is centre.
    function automatic logic [2:0] circ_row(input logic [3:0] k);
        logic [2:0] t [16];
        t = '{3'd0,3'd0,3'd1,3'd2,3'd3,3'd4,3'd5,3'd6,
              3'd6,3'd6,3'd5,3'd4,3'd3,3'd2,3'd1,3'd0};
        return t[k];
    endfunction

    function automatic logic [2:0] circ_col(input logic [3:0] k);
        logic [2:0] t [16];
        t = '{3'd3,3'd4,3'd5,3'd6,3'd6,3'd6,3'd5,3'd4,
              3'd3,3'd2,3'd1,3'd0,3'd0,3'd0,3'd1,3'd2};
        return t[k];
    endfunction

endpackage

### hw/rtl/fcd_front.sv
// Front end: line stores, 7x7 window, position counters, candidate selection.
module fcd_front #(
    parameter int MAX_WIDTH  = fcd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fcd_pkg::MAX_HEIGHT_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic [7:0]    pixel,
    input  logic          frame_start,
    input  logic [10:0]   image_width,
    input  logic [12:0]   image_height,
    output logic          cand_valid,
    output fcd_pkg::cand_t cand
);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // Six line stores packed side by side in one memory word.
    logic [47:0] mem [MAX_WIDTH];
    logic [47:0] rd_q;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_s1_reg;
    logic [RW-1:0] row_s1_reg;
    logic [7:0]    pix_s1_reg;
    logic          v1_reg, v2_reg;
    logic          test_s1_reg;
    logic [6:0][6:0][7:0] win_reg;
    logic [CW-1:0] cx_reg;
    logic [RW-1:0] cy_reg;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic [16:0] w_cl, h_cl;
    logic [47:0] colv;

    always_comb begin
        w_cl = {6'd0, image_width};
        if (w_cl < 17'd7) w_cl = 17'd7;
        if (w_cl > 17'(MAX_WIDTH)) w_cl = 17'(MAX_WIDTH);
        h_cl = {4'd0, image_height};
        if (h_cl < 17'd7) h_cl = 17'd7;
        if (h_cl > 17'(MAX_HEIGHT)) h_cl = 17'(MAX_HEIGHT);
        col_cur = frame_start ? '0 : col_reg;
        row_cur = frame_start ? '0 : row_reg;
        if (17'(col_cur) + 17'd1 >= w_cl) begin
            col_next = '0;
            row_next = (17'(row_cur) + 17'd1 >= h_cl) ? '0 : row_cur + 1'b1;
        end else begin
            col_next = col_cur + 1'b1;
            row_next = row_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
        end else begin
            v1_reg <= in_fire;
            if (in_fire) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
        if (in_fire) begin
            rd_q        <= mem[col_cur];
            col_s1_reg  <= col_cur;
            row_s1_reg  <= row_cur;
            pix_s1_reg  <= pixel;
            test_s1_reg <= (col_cur >= CW'(6)) && (row_cur >= RW'(6))
                           && (17'(col_cur) < w_cl);
        end
    end

    assign colv = {pix_s1_reg, rd_q[47:8]};

    // Stage 2: write back the shifted column, slide the window.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg  <= 1'b0;
            win_reg <= '0;
        end else begin
            v2_reg <= v1_reg && test_s1_reg;
            if (v1_reg) begin
                for (int r = 0; r < 7; r++) begin
                    for (int c = 0; c < 6; c++) win_reg[r][c] <= win_reg[r][c+1];
                    win_reg[r][6] <= (r == 0) ? rd_q[7:0] : colv[(r-1)*8 +: 8];
                end
            end
        end
        if (v1_reg) begin
            mem[col_s1_reg] <= colv;
            cx_reg <= col_s1_reg - CW'(3);
            cy_reg <= row_s1_reg - RW'(3);
        end
    end

    assign cand_valid = v2_reg;
    always_comb begin
        cand.x   = 10'(cx_reg);
        cand.y   = 12'(cy_reg);
        cand.ctr = win_reg[3][3];
        for (int k = 0; k < 16; k++)
            cand.circ[k] = win_reg[fcd_pkg::circ_row(4'(k))][fcd_pkg::circ_col(4'(k))];
    end
endmodule

### hw/rtl/fcd_fifo.sv
// Small queue between front end and back end.
module fcd_fifo #(
    parameter int DEPTH = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  fcd_pkg::cand_t wr_data,
    input  logic          rd_en,
    output logic          rd_valid,
    output fcd_pkg::cand_t rd_data,
    output logic [$clog2(DEPTH):0] level
);
    localparam int AW = $clog2(DEPTH);
    fcd_pkg::cand_t q [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
        if (wr_en) q[wp_reg] <= wr_data;
    end
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = q[rp_reg];
    assign level    = cnt_reg;
endmodule

### hw/rtl/fcd_back.sv
// Back end: threshold classify, pretest, arc search, score, output register.
module fcd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  fcd_pkg::cand_t   cand,
    input  fcd_pkg::thr_cfg_t cfg,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [9:0]       m_x,
    output logic [11:0]      m_y,
    output logic [11:0]      m_score
);
    // Stage A: classify and partial sums.
    logic        a_v_reg;
    logic [15:0] a_b_reg, a_d_reg;
    logic [9:0]  a_x_reg;
    logic [11:0] a_y_reg;
    logic [3:0][9:0] a_ps_reg;
    logic        b_v_reg;
    logic [9:0]  b_x_reg;
    logic [11:0] b_y_reg;
    logic [11:0] b_sc_reg;
    logic        b_hit_reg;
    logic        o_v_reg;
    logic [9:0]  o_x_reg;
    logic [11:0] o_y_reg;
    logic [11:0] o_sc_reg;
    logic        adv_b, adv_a, adv_in;

    logic [15:0] hi_lim, lo_lim;
    logic [15:0] bri, drk;
    logic [3:0][9:0] ps;
    logic [7:0]  df;

    always_comb begin
        hi_lim = 16'((8'd100 + 8'(cfg.ratio)) * cand.ctr);
        lo_lim = (cfg.ratio > 7'd100) ? 16'd0
                 : 16'((8'd100 - 8'(cfg.ratio)) * cand.ctr);
        ps = '0;
        for (int k = 0; k < 16; k++) begin
            bri[k] = 16'(cand.circ[k] * 7'd100) > hi_lim;
            drk[k] = 16'(cand.circ[k] * 7'd100) < lo_lim;
            df = (cand.circ[k] > cand.ctr) ? cand.circ[k] - cand.ctr
                                           : cand.ctr - cand.circ[k];
            ps[k/4] = ps[k/4] + 10'(df);
        end
    end

    // Stage B: pretest and arc search on the registered flags.
    logic [2:0]  cnt;
    logic [4:0]  need;
    logic [31:0] bb, dd;
    logic [15:0] rb, rd;
    logic        hit;
    always_comb begin
        cnt = 3'(a_b_reg[0] | a_d_reg[0]) + 3'(a_b_reg[4] | a_d_reg[4])
            + 3'(a_b_reg[8] | a_d_reg[8]) + 3'(a_b_reg[12] | a_d_reg[12]);
        need = (cfg.arc == 5'd0) ? 5'd1 : (cfg.arc > 5'd16) ? 5'd16 : cfg.arc;
        bb = {a_b_reg, a_b_reg};
        dd = {a_d_reg, a_d_reg};
        rb = a_b_reg;
        rd = a_d_reg;
        // AND of shifted copies: rb[s] holds when bits s..s+need-1 all set.
        for (int i = 1; i < 16; i++) begin
            if (5'(i) < need) begin
                rb = rb & bb[i +: 16];
                rd = rd & dd[i +: 16];
            end
        end
        hit = (cnt >= cfg.pre) && ((rb != '0) || (rd != '0));
    end

    assign adv_b  = !o_v_reg || m_ready;
    assign adv_a  = !b_v_reg || adv_b;
    assign adv_in = !a_v_reg || adv_a;
    assign in_ready = adv_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end else begin
            if (adv_in) a_v_reg <= in_valid;
            if (adv_a)  b_v_reg <= a_v_reg;
            if (adv_b)  o_v_reg <= b_v_reg && b_hit_reg;
        end
        if (adv_in && in_valid) begin
            a_b_reg  <= bri;
            a_d_reg  <= drk;
            a_ps_reg <= ps;
            a_x_reg  <= cand.x;
            a_y_reg  <= cand.y;
        end
        if (adv_a && a_v_reg) begin
            b_hit_reg <= hit;
            b_sc_reg  <= 12'(a_ps_reg[0]) + 12'(a_ps_reg[1])
                       + 12'(a_ps_reg[2]) + 12'(a_ps_reg[3]);
            b_x_reg   <= a_x_reg;
            b_y_reg   <= a_y_reg;
        end
        if (adv_b && b_v_reg) begin
            o_x_reg  <= b_x_reg;
            o_y_reg  <= b_y_reg;
            o_sc_reg <= b_sc_reg;
        end
    end

    assign m_valid = o_v_reg;
    assign m_x     = o_x_reg;
    assign m_y     = o_y_reg;
    assign m_score = o_sc_reg;
endmodule

### hw/rtl/fast_corner_detector_unit.sv
// FAST 9/16 style corner detector for a raster pixel stream.
// Throughput: one pixel per cycle; input stalls only when result backpressure fills the queue.
// Pipeline: 2 front-end stages, then the candidate queue, then 3 back-end stages (A, B, output register).
// Reset (aresetn, synchronous, active low) clears counters, window and queue;
// configuration registers return to their documented defaults.
module fast_corner_detector_unit #(
    parameter int MAX_WIDTH  = fcd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fcd_pkg::MAX_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel[7:0]
    input  logic        s_tuser,   // frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // corner_x[9:0], corner_y[21:10], score[33:22], zero pad
    input  logic        cfg_we,
    input  logic [fcd_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [fcd_pkg::CFG_DW-1:0] cfg_wdata
);
    localparam int QD = 8;

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    fcd_pkg::thr_cfg_t thr_reg;

    // Register writes; out-of-range indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd1024;
            height_reg <= 13'd4096;
            thr_reg    <= '{ratio: 7'd20, arc: 5'd9, pre: 3'd3};
        end else if (cfg_we) begin
            case (cfg_addr)
                fcd_pkg::REG_WIDTH:  width_reg  <= cfg_wdata[10:0];
                fcd_pkg::REG_HEIGHT: height_reg <= cfg_wdata;
                fcd_pkg::REG_RATIO:  thr_reg.ratio <= cfg_wdata[6:0];
                fcd_pkg::REG_ARC:    thr_reg.arc   <= cfg_wdata[4:0];
                fcd_pkg::REG_PRE:    thr_reg.pre   <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    logic in_fire;
    logic cand_valid;
    fcd_pkg::cand_t cand, q_data;
    logic q_valid, q_rd, bk_ready;
    logic [$clog2(QD):0] q_level;
    logic [9:0]  rx;
    logic [11:0] ry, rs;

    // Hold input when the queue could overflow with candidates still in the
    // two-stage front end (worst case two in flight).
    assign s_tready = (q_level <= ($clog2(QD)+1)'(QD - 3));
    assign in_fire  = s_tvalid && s_tready;

    fcd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .aclk, .aresetn, .in_fire,
        .pixel(s_tdata), .frame_start(s_tuser),
        .image_width(width_reg), .image_height(height_reg),
        .cand_valid, .cand
    );

    assign q_rd = q_valid && bk_ready;

    fcd_fifo #(.DEPTH(QD)) u_fifo (
        .aclk, .aresetn, .wr_en(cand_valid), .wr_data(cand),
        .rd_en(q_rd), .rd_valid(q_valid), .rd_data(q_data), .level(q_level)
    );

    fcd_back u_back (
        .aclk, .aresetn, .in_valid(q_valid), .in_ready(bk_ready),
        .cand(q_data), .cfg(thr_reg),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_x(rx), .m_y(ry), .m_score(rs)
    );

    assign m_tdata = {6'd0, rs, ry, rx};

    // Queue never overflows.
    a_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        q_level <= ($clog2(QD)+1)'(QD))
        else $error("candidate queue overflow");

    // Score never exceeds 16*255.
    a_score: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> rs <= 12'd4080)
        else $error("score out of range");

    // Queue only drains when it holds something.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        q_rd |-> q_level != '0)
        else $error("read from empty queue");
endmodule

### tb/fcd_checker.sv
// Corner checker: predicts corner results from the pixel stream and compares them.
`timescale 1ns / 100ps

module fcd_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [39:0]       m_tdata,
    input  logic              cfg_we,
    input  logic [fcd_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [fcd_pkg::CFG_DW-1:0] cfg_wdata,
    output int                fail_count,
    output int                pending,
    output int                corners_seen
);
    // lowest field last, so the layout matches m_tdata
    typedef struct packed {
        logic [11:0] score;
        logic [11:0] y;
        logic [9:0]  x;
    } corner_t;

    localparam int LW = fcd_pkg::MAX_WIDTH_DEF;

    // circle walk, column then row offset from the centre
    localparam int DX [16] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};
    localparam int DY [16] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};

    corner_t     corner_q[$];
    logic [7:0]  rows [6][LW];
    logic [7:0]  win [7][7];
    int unsigned col_cnt, row_cnt;
    logic [10:0] img_w;
    logic [12:0] img_h;
    logic [6:0]  ratio;
    logic [4:0]  arc;
    logic [2:0]  pre;

    function automatic int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Advance the window by one pixel and queue a corner if the centre passes.
    task automatic detect_corner(input logic [7:0] pix, input logic fs);
        int unsigned w, h, col, row, cnt, sc, need;
        logic [7:0]  colv [7];
        int          ci, p, hi_lim, lo_lim;
        logic        bri [16], drk [16];
        logic        hit, allb, alld;
        corner_t     c;
        w = clampv(img_w, 7, LW);
        h = clampv(img_h, 7, fcd_pkg::MAX_HEIGHT_DEF);
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        col = col_cnt;
        row = row_cnt;
        for (int r = 0; r < 6; r++) colv[r] = (col < LW) ? rows[r][col] : 8'd0;
        colv[6] = pix;
        if (col < LW) for (int r = 0; r < 6; r++) rows[r][col] = colv[r+1];
        for (int r = 0; r < 7; r++) begin
            for (int k = 0; k < 6; k++) win[r][k] = win[r][k+1];
            win[r][6] = colv[r];
        end
        if (col >= 6 && row >= 6 && col < w) begin
            ci = win[3][3];
            hi_lim = (100 + int'(ratio)) * ci;
            lo_lim = (100 - int'(ratio)) * ci;
            cnt = 0;
            sc = 0;
            hit = 0;
            for (int k = 0; k < 16; k++) begin
                p = win[3+DY[k]][3+DX[k]];
                bri[k] = 100 * p > hi_lim;
                drk[k] = 100 * p < lo_lim;
                sc += (p > ci) ? p - ci : ci - p;
            end
            for (int k = 0; k < 16; k += 4) if (bri[k] || drk[k]) cnt++;
            if (cnt >= pre) begin
                need = clampv(arc, 1, 16);
                for (int s = 0; s < 16; s++) begin
                    allb = 1;
                    alld = 1;
                    for (int k = 0; k < need; k++) begin
                        if (!bri[(s+k)%16]) allb = 0;
                        if (!drk[(s+k)%16]) alld = 0;
                    end
                    if (allb || alld) hit = 1;
                end
            end
            if (hit) begin
                c.x = 10'(col - 3);
                c.y = 12'(row - 3);
                c.score = 12'(sc);
                corner_q.insert(corner_q.size(), c);
            end
        end
        if (col + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col_cnt = col + 1;
        end
    endtask

    always @(posedge aclk) begin
        corner_t got, want;
        if (!aresetn) begin
            img_w = 11'd1024;
            img_h = 13'd4096;
            ratio = 7'd20;
            arc = 5'd9;
            pre = 3'd3;
            col_cnt = 0;
            row_cnt = 0;
            foreach (win[r, k]) win[r][k] = 8'd0;
            foreach (rows[r, k]) rows[r][k] = 8'd0;
            corner_q.delete();
            fail_count = 0;
            corners_seen = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    fcd_pkg::REG_WIDTH:  img_w = cfg_wdata[10:0];
                    fcd_pkg::REG_HEIGHT: img_h = cfg_wdata[12:0];
                    fcd_pkg::REG_RATIO:  ratio = cfg_wdata[6:0];
                    fcd_pkg::REG_ARC:    arc = cfg_wdata[4:0];
                    fcd_pkg::REG_PRE:    pre = cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) detect_corner(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                got = m_tdata[33:0];
                corners_seen++;
                if (corner_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected corner, expected none, actual x=%0d y=%0d score=%0d",
                             $time, got.x, got.y, got.score);
                end else begin
                    want = corner_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.score !== want.score) begin
                        fail_count++;
                        $display("%0t: corner mismatch, expected x=%0d y=%0d score=%0d,",
                                 $time, want.x, want.y, want.score);
                        $display("    actual x=%0d y=%0d score=%0d", got.x, got.y, got.score);
                    end
                end
            end
        end
        pending = corner_q.size();
    end
endmodule

### tb/tb.sv
// Testbench top: pixel stimulus, configuration phases and verdict for the corner detector.
`timescale 1ns / 100ps

module tb;
    localparam int LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [7:0]        s_tdata = 0;  // pixel[7:0]
    logic              s_tuser = 0;  // frame_start
    logic              m_tvalid;
    logic              m_tready = 0;
    logic [39:0]       m_tdata;      // corner_x[9:0], corner_y[21:10], score[33:22], zero pad
    logic              cfg_we = 0;
    logic [fcd_pkg::CFG_AW-1:0] cfg_addr = fcd_pkg::REG_WIDTH;
    logic [fcd_pkg::CFG_DW-1:0] cfg_wdata = 0;

    int fail_count, pending, corners_seen;
    int cycles = 0;
    int pix_sent = 0;
    int send_idle = 0;   // percent of cycles the sender stays idle
    int recv_stall = 0;  // percent of cycles the receiver stalls
    logic hold_go = 0;   // start the long receiver hold-off
    int hold_cnt = 0;    // hold-off cycles spent, counted by the receiver

    always #1 aclk = ~aclk;

    fast_corner_detector_unit DUT (.*);

    fcd_checker u_check (.*);

    // Receiver: random stall, plus one long hold-off counted here so the block backs up.
    always @(posedge aclk) begin
        if (hold_go && hold_cnt < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Watchdog: end the run if the block stops moving.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Raise the write for one edge; the caller drops cfg_we after the last write.
    task automatic write_reg(input logic [fcd_pkg::CFG_AW-1:0] addr, input int val);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= val[fcd_pkg::CFG_DW-1:0];
        @(posedge aclk);
    endtask

    // Drop valid, wait for every predicted corner, then let the pipeline drain.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_cfg(input int w, input int h, input int r, input int a, input int p);
        drain();
        write_reg(fcd_pkg::REG_WIDTH, w);
        write_reg(fcd_pkg::REG_HEIGHT, h);
        write_reg(fcd_pkg::REG_RATIO, r);
        write_reg(fcd_pkg::REG_ARC, a);
        write_reg(fcd_pkg::REG_PRE, p);
        cfg_we <= 1'b0;
    endtask

    // Hold the pixel until the block takes it; idle first at the current rate.
    task automatic send_pixel(input logic [7:0] pix, input logic fs);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tuser <= fs;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pix_sent++;
    endtask

    // Blocky texture with extremes so the segment test fires often.
    function automatic logic [7:0] texture();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 8'd255 : 8'd0;
            1: return 8'($urandom);
            2: return 8'($urandom_range(110, 140));
            default: return 8'($urandom_range(1) ? $urandom_range(200, 255)
                                                 : $urandom_range(0, 40));
        endcase
    endfunction

    // Stream n pixels starting a frame; noise adds the odd stray frame start.
    task automatic send_frame(input int n, input bit noise);
        for (int i = 0; i < n; i++)
            send_pixel(texture(), i == 0 || (noise && $urandom_range(60) == 0));
    endtask

    initial begin
        int mode;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: a short burst on the widest rows.
        send_frame(24, 0);

        // Hardest arc and pretest, ratio at its top legal value.
        set_cfg(8, 7, 100, 16, 4);
        send_frame(56, 0);
        // Width clamps up to 7, height down to the maximum, arc 0 clamps to 1.
        // Ratio above 100: never darker. Pretest above four: never a corner.
        set_cfg(3, 8191, 127, 0, 7);
        send_frame(49, 0);
        // Width clamps to the maximum; arc above 16 clamps.
        set_cfg(2047, 7, 50, 31, 2);
        send_frame(10, 0);
        // Height wrap: two frames back to back with a single frame start.
        set_cfg(7, 7, 20, 9, 3);
        send_frame(98, 0);

        // Long receiver hold-off with the sender flat out and nearly every centre a corner.
        set_cfg(12, 4096, 0, 1, 0);
        send_idle = 0;
        recv_stall = 0;
        hold_go <= 1'b1;
        send_frame(120, 0);

        // Random phases, one per idle pattern.
        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 79; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 79; end
                default: begin send_idle = 21; recv_stall = 21; end
            endcase
            set_cfg($urandom_range(7, 9), $urandom_range(7, 9), $urandom_range(0, 60),
                    $urandom_range(0, 12), $urandom_range(0, 3));
            send_frame($urandom_range(49, 63), $urandom_range(1));
        end

        drain();
        send_idle = 0;
        recv_stall = 0;
        repeat (20) @(posedge aclk);
        $display("Covered %0d pixels over many size and threshold settings, %0d corners checked.",
                 pix_sent, corners_seen);
        $display("Idle patterns, a long output hold-off and frame wraps were exercised.");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
